@@ src/four_channel_phase_dimmer_macros.svh @@
// Assertion helpers for the dimmer top-level module.
`ifndef FOUR_CHANNEL_PHASE_DIMMER_MACROS_SVH
`define FOUR_CHANNEL_PHASE_DIMMER_MACROS_SVH

// Checked at every rising clock edge outside reset.
`define FCPD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define FCPD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/fcpd_pkg.sv @@
package fcpd_pkg;

   localparam int NUM_CHANNELS = 4;
   localparam int TICK_WIDTH   = 16;
   localparam int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int CH_PAD_W     = (CH_W > 2) ? CH_W : 2;
   localparam int GATE_PAD_W   = (NUM_CHANNELS > 4) ? NUM_CHANNELS : 4;
   localparam int ALU_W        = (TICK_WIDTH > 16) ? TICK_WIDTH : 16;
   localparam int LEVEL_W      = 8;
   localparam int PULSE_W      = 8;
   localparam int TIME_W       = 12;
   localparam int CSR_W        = 8;

   localparam logic [LEVEL_W-1:0] FIRE_STEP = 8'd10;
   localparam logic [CH_W-1:0]    LAST_CH   = CH_W'(NUM_CHANNELS - 1);

   typedef enum logic [1:0] {
      OP_TICK       = 2'd0,
      OP_ZERO_CROSS = 2'd1,
      OP_SET_LEVEL  = 2'd2,
      OP_NONE       = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CSR_GATE_PULSE_LEN = 2'd0,
      CSR_LEVEL_MIN      = 2'd1,
      CSR_LEVEL_MAX      = 2'd2,
      CSR_SCALE_FREQ     = 2'd3
   } csr_idx_type;

   typedef enum logic [2:0] {
      ALU_ADD,
      ALU_MAX,
      ALU_MIN,
      ALU_MUL,
      ALU_EQ
   } alu_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TICK_INC,
      ST_PULSE,
      ST_SCAN,
      ST_CLAMP_LO,
      ST_CLAMP_HI,
      ST_MUL,
      ST_X10,
      ST_DONE
   } state_type;

   typedef struct packed {
      op_type               operation;
      logic [1:0]           channel;
      logic [LEVEL_W-1:0]   level;
   } req_type;

   typedef struct packed {
      logic [3:0]  gates;
      logic [15:0] tick_count;
   } rsp_type;

   typedef struct packed {
      alu_op_type       op;
      logic [ALU_W-1:0] a;
      logic [ALU_W-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic [ALU_W-1:0] result;
      logic             equal;
   } alu_rsp_type;

endpackage

@@ src/fcpd_alu.sv @@
module fcpd_alu (
   input  fcpd_pkg::alu_req_type alu_req,
   output fcpd_pkg::alu_rsp_type alu_rsp
);
   import fcpd_pkg::*;

   logic [2*LEVEL_W-1:0] product;

   assign product = alu_req.a[LEVEL_W-1:0] * alu_req.b[LEVEL_W-1:0];

   always_comb begin
      alu_rsp.equal = (alu_req.a == alu_req.b);
      unique case (alu_req.op)
         ALU_ADD: alu_rsp.result = alu_req.a + alu_req.b;
         ALU_MAX: alu_rsp.result = (alu_req.a > alu_req.b) ? alu_req.a : alu_req.b;
         ALU_MIN: alu_rsp.result = (alu_req.a < alu_req.b) ? alu_req.a : alu_req.b;
         ALU_MUL: alu_rsp.result = ALU_W'(product);
         ALU_EQ:  alu_rsp.result = '0;
         default: alu_rsp.result = '0;
      endcase
   end

endmodule

@@ src/four_channel_phase_dimmer.sv @@
// A tick runs through the increment, pulse and scan states to done, a level
// write through the clamp, multiply and times-ten states, a zero crossing or
// an empty item straight to done. New items wait until the result is issued;
// the tick scan compares one channel per cycle in the shared arithmetic unit.
// Reset is synchronous and active high; it restores the register defaults and
// clears the counters, the firing times and the gates.
`include "four_channel_phase_dimmer_macros.svh"

module four_channel_phase_dimmer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  fcpd_pkg::req_type    req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output fcpd_pkg::rsp_type    rsp_payload,
   input  logic                 csr_wr_en,
   input  logic [1:0]           csr_index,
   input  logic [7:0]           csr_wdata
);
   import fcpd_pkg::*;

   state_type               state_ff, state_in;
   req_type                 item_ff, item_in;
   logic [ALU_W-1:0]        work_ff, work_in;
   logic [CH_W-1:0]         idx_ff, idx_in;
   logic [TICK_WIDTH-1:0]   tick_ff, tick_in;
   logic [PULSE_W-1:0]      pulse_ff, pulse_in;
   logic [NUM_CHANNELS-1:0] gate_ff, gate_in;
   logic [TIME_W-1:0]       active_ff [NUM_CHANNELS];
   logic [TIME_W-1:0]       active_in [NUM_CHANNELS];
   logic [TIME_W-1:0]       pending_ff [NUM_CHANNELS];
   logic [TIME_W-1:0]       pending_in [NUM_CHANNELS];
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_payload_ff, rsp_payload_in;

   logic [CSR_W-1:0]        pulse_len_ff, level_min_ff, level_max_ff, scale_ff;

   alu_req_type             alu_req;
   alu_rsp_type             alu_rsp;
   logic                    req_xfer;
   logic                    rsp_free;
   logic [PULSE_W-1:0]      pulse_next;
   logic [CH_PAD_W-1:0]     ch_wide;
   logic [GATE_PAD_W-1:0]   gate_wide;
   logic [ALU_W-1:0]        tick_wide;

   fcpd_alu u_alu (
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   assign req_stall   = (state_ff != ST_IDLE);
   assign req_xfer    = req_valid && !req_stall;
   assign rsp_free    = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;
   assign pulse_next  = alu_rsp.result[PULSE_W-1:0];
   assign ch_wide     = CH_PAD_W'(item_ff.channel);
   assign gate_wide   = GATE_PAD_W'(gate_ff);
   assign tick_wide   = ALU_W'(tick_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_payload.operation)
                  OP_TICK:      state_in = ST_TICK_INC;
                  OP_SET_LEVEL: state_in = ST_CLAMP_LO;
                  default:      state_in = ST_DONE;
               endcase
            end
         end
         ST_TICK_INC: state_in = ST_PULSE;
         ST_PULSE:    state_in = ST_SCAN;
         ST_SCAN: begin
            if (idx_ff == LAST_CH) begin
               state_in = ST_DONE;
            end
         end
         ST_CLAMP_LO: state_in = ST_CLAMP_HI;
         ST_CLAMP_HI: state_in = ST_MUL;
         ST_MUL:      state_in = ST_X10;
         ST_X10:      state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      item_in        = item_ff;
      work_in        = work_ff;
      idx_in         = idx_ff;
      tick_in        = tick_ff;
      pulse_in       = pulse_ff;
      gate_in        = gate_ff;
      active_in      = active_ff;
      pending_in     = pending_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      alu_req.op     = ALU_EQ;
      alu_req.a      = '0;
      alu_req.b      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            idx_in = '0;
            if (req_xfer) begin
               item_in = req_payload;
               work_in = ALU_W'(req_payload.level);
               if (req_payload.operation == OP_ZERO_CROSS) begin
                  active_in = pending_ff;
                  tick_in   = '0;
               end
            end
         end
         ST_TICK_INC: begin
            alu_req.op = ALU_ADD;
            alu_req.a  = tick_wide;
            alu_req.b  = ALU_W'(1);
            tick_in    = alu_rsp.result[TICK_WIDTH-1:0];
         end
         ST_PULSE: begin
            alu_req.op = ALU_ADD;
            alu_req.a  = ALU_W'(pulse_ff);
            alu_req.b  = ALU_W'(1);
            if (pulse_ff != '0) begin
               if (pulse_next == pulse_len_ff) begin
                  gate_in  = '0;
                  pulse_in = '0;
               end else begin
                  pulse_in = pulse_next;
               end
            end
         end
         ST_SCAN: begin
            alu_req.op = ALU_EQ;
            alu_req.a  = ALU_W'(active_ff[idx_ff]);
            alu_req.b  = tick_wide;
            if (alu_rsp.equal) begin
               gate_in[idx_ff] = 1'b1;
               pulse_in        = PULSE_W'(1);
            end
            idx_in = (idx_ff == LAST_CH) ? '0 : idx_ff + CH_W'(1);
         end
         ST_CLAMP_LO: begin
            alu_req.op = ALU_MAX;
            alu_req.a  = work_ff;
            alu_req.b  = ALU_W'(level_min_ff);
            work_in    = alu_rsp.result;
         end
         ST_CLAMP_HI: begin
            alu_req.op = ALU_MIN;
            alu_req.a  = work_ff;
            alu_req.b  = ALU_W'(level_max_ff);
            work_in    = alu_rsp.result;
         end
         ST_MUL: begin
            alu_req.op = ALU_MUL;
            alu_req.a  = work_ff;
            alu_req.b  = ALU_W'(scale_ff);
            work_in    = alu_rsp.result;
         end
         ST_X10: begin
            alu_req.op = ALU_MUL;
            alu_req.a  = ALU_W'(work_ff[15:8]);
            alu_req.b  = ALU_W'(FIRE_STEP);
            if (int'(item_ff.channel) < NUM_CHANNELS) begin
               pending_in[ch_wide[CH_W-1:0]] = alu_rsp.result[TIME_W-1:0];
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in              = 1'b1;
               rsp_payload_in.gates      = gate_wide[3:0];
               rsp_payload_in.tick_count = tick_wide[15:0];
            end
         end
         default: begin
            idx_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         tick_ff      <= '0;
         pulse_ff     <= '0;
         gate_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            active_ff[i]  <= '0;
            pending_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         tick_ff      <= tick_in;
         pulse_ff     <= pulse_in;
         gate_ff      <= gate_in;
         rsp_valid_ff <= rsp_valid_in;
         active_ff    <= active_in;
         pending_ff   <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff        <= item_in;
      work_ff        <= work_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_len_ff <= 8'd5;
         level_min_ff <= 8'd26;
         level_max_ff <= 8'd229;
         scale_ff     <= 8'd84;
      end else if (csr_wr_en) begin
         unique case (csr_idx_type'(csr_index))
            CSR_GATE_PULSE_LEN: pulse_len_ff <= csr_wdata;
            CSR_LEVEL_MIN:      level_min_ff <= csr_wdata;
            CSR_LEVEL_MAX:      level_max_ff <= csr_wdata;
            CSR_SCALE_FREQ:     scale_ff     <= csr_wdata;
            default:            scale_ff     <= scale_ff;
         endcase
      end
   end

   `FCPD_ASSERT(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE), "result became valid outside the done state")
   `FCPD_ASSERT(a_idx_idle, clock, reset, (state_ff != ST_SCAN) |-> (idx_ff == '0), "scan index not parked outside the scan")
   `FCPD_ASSERT(a_zc_clears, clock, reset, (req_xfer && req_payload.operation == OP_ZERO_CROSS) |=> (tick_ff == '0), "zero crossing did not clear the tick counter")
   `FCPD_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (state_ff == ST_IDLE && !rsp_valid_ff),
                       "reset did not return the sequencer to idle")

endmodule
